// ===== src/drf_pkg.sv =====
// Shared types and constants for the depth disparity refit pipeline.
package drf_pkg;

    localparam int KQ_W = 32;
    localparam logic [KQ_W-1:0] K_Q16 = 32'd2803346100;
    localparam logic [15:0] K_HI = K_Q16[31:16];

    localparam int RECIP_STAGES = 4;
    localparam int RECIP_STEPS = KQ_W / RECIP_STAGES;
    localparam int QUOT_STAGES = 4;
    localparam int QUOT_STEPS = 16 / QUOT_STAGES;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_GAIN = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_HCURVE = 3'd2;
    localparam logic [2:0] REG_VCURVE = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;
    localparam logic [2:0] REG_CX = 3'd5;
    localparam logic [2:0] REG_CY = 3'd6;

    typedef struct packed {
        logic signed [31:0] depth_gain;
        logic signed [31:0] disparity_offset;
        logic signed [31:0] horizontal_curve;
        logic signed [31:0] vertical_curve;
        logic [11:0]        max_radius;
        logic [15:0]        center_x;
        logic [15:0]        center_y;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        depth;
        logic signed [16:0] u;
        logic signed [16:0] v;
        logic               nz;
    } side_t;

    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [31:0] den;
    } quot_t;

endpackage

// ===== src/drf_if.sv =====
// Stream interfaces for pixel input and refitted depth output.
interface drf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth_mm;
    logic [11:0] column;
    logic [11:0] row;
    modport source (output valid, depth_mm, column, row, input ready);
    modport sink (input valid, depth_mm, column, row, output ready);
endinterface

interface drf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fitted_depth_mm;
    modport source (output valid, fitted_depth_mm, input ready);
    modport sink (input valid, fitted_depth_mm, output ready);
endinterface

// ===== src/drf_cfg.sv =====
// APB register file for the refit coefficients.
module drf_cfg
    import drf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);
    cfg_t cfg_reg;
    logic wr;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_gain <= 32'sd16777216;
            cfg_reg.disparity_offset <= '0;
            cfg_reg.horizontal_curve <= '0;
            cfg_reg.vertical_curve <= '0;
            cfg_reg.max_radius <= 12'd150;
            cfg_reg.center_x <= 16'd5120;
            cfg_reg.center_y <= 16'd3840;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_GAIN:   cfg_reg.depth_gain <= pwdata;
                REG_OFFSET: cfg_reg.disparity_offset <= pwdata;
                REG_HCURVE: cfg_reg.horizontal_curve <= pwdata;
                REG_VCURVE: cfg_reg.vertical_curve <= pwdata;
                REG_RADIUS: cfg_reg.max_radius <= pwdata[11:0];
                REG_CX:     cfg_reg.center_x <= pwdata[15:0];
                REG_CY:     cfg_reg.center_y <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_GAIN:   prdata = cfg_reg.depth_gain;
            REG_OFFSET: prdata = cfg_reg.disparity_offset;
            REG_HCURVE: prdata = cfg_reg.horizontal_curve;
            REG_VCURVE: prdata = cfg_reg.vertical_curve;
            REG_RADIUS: prdata = {20'd0, cfg_reg.max_radius};
            REG_CX:     prdata = {16'd0, cfg_reg.center_x};
            REG_CY:     prdata = {16'd0, cfg_reg.center_y};
            default:    prdata = '0;
        endcase
    end
endmodule

// ===== src/drf_recip.sv =====
// Pipelined restoring divider: disparity = K / depth, eight quotient bits per stage.
module drf_recip
    import drf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  side_t       in_side,
    output logic        out_valid,
    output side_t       out_side,
    output logic [31:0] recip
);
    logic        vld_reg  [RECIP_STAGES];
    side_t       side_reg [RECIP_STAGES];
    logic [15:0] rem_reg  [RECIP_STAGES];
    logic [31:0] quo_reg  [RECIP_STAGES];

    for (genvar s = 0; s < RECIP_STAGES; s++)
    begin : g_stage
        logic        vld_in;
        side_t       side_in;
        logic [15:0] rem_in;
        logic [31:0] quo_in;
        logic [15:0] rem_next;
        logic [31:0] quo_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign side_in = in_side;
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign side_in = side_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [16:0] t;
            logic [15:0] r;
            logic [31:0] q;
            r = rem_in;
            q = quo_in;
            for (int j = 0; j < RECIP_STEPS; j++)
            begin
                t = {r, K_Q16[KQ_W - 1 - RECIP_STEPS * s - j]};
                q = {q[30:0], 1'b0};
                if (t >= {1'b0, side_in.depth})
                begin
                    t = t - {1'b0, side_in.depth};
                    q[0] = 1'b1;
                end
                r = t[15:0];
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[s] <= side_in;
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[RECIP_STAGES-1];
    assign out_side = side_reg[RECIP_STAGES-1];
    assign recip = quo_reg[RECIP_STAGES-1];
endmodule

// ===== src/drf_fit.sv =====
// Refit polynomial: gain and curve products, radius mask, disparity sum and range checks.
module drf_fit
    import drf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  side_t       in_side,
    input  logic [31:0] recip,
    output logic        out_valid,
    output quot_t       out_q
);
    // stage b: squares and gain product
    logic               b_vld_reg;
    logic               b_nz_reg;
    logic [31:0]        b_u2_reg;
    logic [31:0]        b_v2_reg;
    logic signed [63:0] b_pg_reg;
    // stage c: curve products and mask
    logic               c_vld_reg;
    logic               c_ok_reg;
    logic signed [39:0] c_gt_reg;
    logic signed [63:0] c_hp_reg;
    logic signed [63:0] c_vp_reg;
    // stage e: partial sums
    logic               e_vld_reg;
    logic               e_ok_reg;
    logic signed [40:0] e_s_reg;
    logic signed [32:0] e_hv_reg;
    // stage f: fitted disparity
    logic               f_vld_reg;
    logic               f_ok_reg;
    logic signed [41:0] f_d_reg;
    // stage g: divider setup
    logic               g_vld_reg;
    quot_t              g_q_reg;

    logic signed [33:0] u2_full;
    logic signed [33:0] v2_full;
    logic signed [64:0] pg_full;
    logic signed [64:0] hp_full;
    logic signed [64:0] vp_full;
    logic signed [63:0] gt_sh;
    logic [32:0]        r2_sum;
    logic [23:0]        rad2;
    logic signed [63:0] hp_sh;
    logic signed [63:0] vp_sh;
    logic signed [40:0] s_next;
    logic signed [32:0] hv_next;
    logic signed [41:0] d_next;
    logic               pos;
    logic               big;
    quot_t              q_next;

    assign u2_full = in_side.u * in_side.u;
    assign v2_full = in_side.v * in_side.v;
    assign pg_full = cfg.depth_gain * $signed({1'b0, recip});

    assign hp_full = cfg.horizontal_curve * $signed({1'b0, b_u2_reg});
    assign vp_full = cfg.vertical_curve * $signed({1'b0, b_v2_reg});
    assign gt_sh = b_pg_reg >>> 24;
    assign r2_sum = {1'b0, b_u2_reg} + {1'b0, b_v2_reg};
    assign rad2 = {12'd0, cfg.max_radius} * {12'd0, cfg.max_radius};

    assign hp_sh = c_hp_reg >>> 32;
    assign vp_sh = c_vp_reg >>> 32;
    assign s_next = 41'(c_gt_reg) + 41'(cfg.disparity_offset);
    assign hv_next = 33'(signed'(hp_sh[31:0])) + 33'(signed'(vp_sh[31:0]));

    assign d_next = 42'(e_s_reg) + 42'(e_hv_reg);

    assign pos = !f_d_reg[41] && (f_d_reg != '0);
    assign big = f_d_reg[41:32] != '0;
    always_comb
    begin
        q_next.zero = !f_ok_reg || !pos || big;
        q_next.den = f_d_reg[31:0];
        q_next.sat = f_d_reg[31:0] <= {16'd0, K_HI};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= in_valid;
            c_vld_reg <= b_vld_reg;
            e_vld_reg <= c_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_nz_reg <= in_side.nz;
            b_u2_reg <= u2_full[31:0];
            b_v2_reg <= v2_full[31:0];
            b_pg_reg <= pg_full[63:0];
            c_ok_reg <= b_nz_reg && (r2_sum < {1'b0, rad2, 8'd0});
            c_gt_reg <= gt_sh[39:0];
            c_hp_reg <= hp_full[63:0];
            c_vp_reg <= vp_full[63:0];
            e_ok_reg <= c_ok_reg;
            e_s_reg <= s_next;
            e_hv_reg <= hv_next;
            f_ok_reg <= e_ok_reg;
            f_d_reg <= d_next;
            g_q_reg <= q_next;
        end
    end

    assign out_valid = g_vld_reg;
    assign out_q = g_q_reg;
endmodule

// ===== src/drf_quot.sv =====
// Pipelined restoring divider: depth = K / fitted disparity, saturation and output register.
module drf_quot
    import drf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  quot_t       in_q,
    output logic        out_valid,
    output logic [15:0] depth_out
);
    logic        vld_reg [QUOT_STAGES];
    quot_t       ctl_reg [QUOT_STAGES];
    logic [31:0] rem_reg [QUOT_STAGES];
    logic [15:0] quo_reg [QUOT_STAGES];
    logic        o_vld_reg;
    logic [15:0] o_depth_reg;
    quot_t       last;

    for (genvar s = 0; s < QUOT_STAGES; s++)
    begin : g_stage
        logic        vld_in;
        quot_t       ctl_in;
        logic [31:0] rem_in;
        logic [15:0] quo_in;
        logic [31:0] rem_next;
        logic [15:0] quo_next;

        if (s == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign ctl_in = in_q;
            assign rem_in = {16'd0, K_HI};
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign ctl_in = ctl_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [32:0] t;
            logic [31:0] r;
            logic [15:0] q;
            r = rem_in;
            q = quo_in;
            for (int j = 0; j < QUOT_STEPS; j++)
            begin
                t = {r, K_Q16[15 - QUOT_STEPS * s - j]};
                q = {q[14:0], 1'b0};
                if (t >= {1'b0, ctl_in.den})
                begin
                    t = t - {1'b0, ctl_in.den};
                    q[0] = 1'b1;
                end
                r = t[31:0];
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctl_reg[s] <= ctl_in;
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign last = ctl_reg[QUOT_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (adv)
            o_vld_reg <= vld_reg[QUOT_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (last.zero)
                o_depth_reg <= '0;
            else if (last.sat)
                o_depth_reg <= 16'hFFFF;
            else
                o_depth_reg <= quo_reg[QUOT_STAGES-1];
        end
    end

    assign out_valid = o_vld_reg;
    assign depth_out = o_depth_reg;
endmodule

// ===== src/depth_pixel_disparity_refit.sv =====
// Top level of the depth pixel disparity refit pipeline.
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+----------------------------
//  pixel    | in  | valid && ready         | depth_mm, column, row
//  result   | out | valid && ready         | fitted_depth_mm
//  apb      | in  | psel&&penable&&pwrite  | paddr, pwdata (7 registers)
//
// One pixel per cycle while the result is not stalled; 4 reciprocal divider stages,
// 5 refit stages, 4 quotient divider stages, output register.
// Reset clears all stage valid bits; coefficients return to defaults.
// A stalled result freezes the whole pipeline; nothing is dropped.
module depth_pixel_disparity_refit
    import drf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    drf_in_if.sink            pixel,
    drf_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    cfg_t        cfg;
    logic        adv;
    side_t       side_in;
    logic        r_valid;
    side_t       r_side;
    logic [31:0] recip;
    logic        f_valid;
    quot_t       f_q;

    assign adv = !result.valid || result.ready;
    assign pixel.ready = adv;

    always_comb
    begin
        side_in.depth = pixel.depth_mm;
        side_in.nz = pixel.depth_mm != '0;
        side_in.u = $signed({1'b0, cfg.center_x}) - $signed({1'b0, pixel.column, 4'd0});
        side_in.v = $signed({1'b0, cfg.center_y}) - $signed({1'b0, pixel.row, 4'd0});
    end

    drf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drf_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pixel.valid),
        .in_side   (side_in),
        .out_valid (r_valid),
        .out_side  (r_side),
        .recip     (recip)
    );

    drf_fit u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .recip     (recip),
        .out_valid (f_valid),
        .out_q     (f_q)
    );

    drf_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_q      (f_q),
        .out_valid (result.valid),
        .depth_out (result.fitted_depth_mm)
    );
endmodule

// ===== test/tb_depth_pixel_disparity_refit.sv =====
// Testbench for depth_pixel_disparity_refit: directed and random pixel streams checked against a refit predictor.
module tb_depth_pixel_disparity_refit;
    import drf_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [15:0] depth_mm;
        logic [11:0] column;
        logic [11:0] row;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    drf_in_if pix();
    drf_out_if res();

    depth_pixel_disparity_refit dut (
        .clk(clk), .rst_n(rst_n), .pixel(pix), .result(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the coefficient registers
    logic signed [31:0] gain_r = 32'sd16777216;
    logic signed [31:0] offset_r = '0;
    logic signed [31:0] hcurve_r = '0;
    logic signed [31:0] vcurve_r = '0;
    logic [11:0] radius_r = 12'd150;
    logic [15:0] cx_r = 16'd5120;
    logic [15:0] cy_r = 16'd3840;

    pixel_t pending_pixels[$];
    logic [15:0] expected_depths[$];
    logic pix_took = 1'b0;
    int pixels_in = 0;
    int depths_out = 0;
    int nonzero_out = 0;
    int saturated_out = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;

    initial
    begin
        pix.valid = 1'b0;
        pix.depth_mm = '0;
        pix.column = '0;
        pix.row = '0;
        res.ready = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] refit_depth(input pixel_t p);
        longint unsigned kq;
        longint unsigned quo;
        longint u, v, u2, v2, lim, disp, dfit;
        kq = K_Q16;
        if (p.depth_mm == 0)
            return 16'd0;
        u = longint'({48'd0, cx_r}) - longint'({48'd0, p.column, 4'd0});
        v = longint'({48'd0, cy_r}) - longint'({48'd0, p.row, 4'd0});
        u2 = u * u;
        v2 = v * v;
        lim = longint'({52'd0, radius_r}) * longint'({52'd0, radius_r}) * 256;
        if (u2 + v2 >= lim)
            return 16'd0;
        disp = longint'(kq / p.depth_mm);
        dfit = ((longint'(gain_r) * disp) >>> 24) + longint'(offset_r)
             + ((longint'(hcurve_r) * u2) >>> 32) + ((longint'(vcurve_r) * v2) >>> 32);
        if (dfit <= 0)
            return 16'd0;
        quo = kq / unsigned'(dfit);
        if (quo > 65535)
            return 16'hFFFF;
        return quo[15:0];
    endfunction

    function automatic bit quiet_window();
        return pixels_in >= 1000 && pixels_in < 1200;
    endfunction

    // pixel driver
    always @(negedge clk)
    begin
        if (rst_n && (!pix.valid || pix_took))
        begin
            if (pending_pixels.size() == 0 || (!quiet_window() && $urandom_range(99) < 19))
            begin
                pix.valid <= 1'b0;
            end
            else
            begin
                pixel_t p;
                p = pending_pixels.pop_front();
                pix.valid <= 1'b1;
                pix.depth_mm <= p.depth_mm;
                pix.column <= p.column;
                pix.row <= p.row;
            end
        end
    end

    // result receiver, with one long hold-off to back up the pipeline
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && pixels_in >= 600)
            begin
                res.ready <= 1'b0;
                hold_left <= 400;
                hold_done <= 1;
            end
            else
            begin
                res.ready <= quiet_window() || $urandom_range(99) >= 19;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        pix_took <= pix.valid && pix.ready;
        if (rst_n && pix.valid && pix.ready)
        begin
            expected_depths.push_back(refit_depth({pix.depth_mm, pix.column, pix.row}));
            pixels_in <= pixels_in + 1;
        end
        if (rst_n && res.valid && res.ready)
        begin
            depths_out <= depths_out + 1;
            if (res.fitted_depth_mm != 0)
                nonzero_out <= nonzero_out + 1;
            if (res.fitted_depth_mm == 16'hFFFF)
                saturated_out <= saturated_out + 1;
            if (expected_depths.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transfer: fitted_depth_mm=%0d", res.fitted_depth_mm);
            end
            else
            begin
                logic [15:0] want;
                want = expected_depths.pop_front();
                if (want !== res.fitted_depth_mm)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("fitted_depth_mm mismatch: expected %0d, got %0d",
                                 want, res.fitted_depth_mm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_GAIN: gain_r = val;
            REG_OFFSET: offset_r = val;
            REG_HCURVE: hcurve_r = val;
            REG_VCURVE: vcurve_r = val;
            REG_RADIUS: radius_r = val[11:0];
            REG_CX: cx_r = val[15:0];
            REG_CY: cy_r = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_pixels.size() == 0 && !pix.valid && expected_depths.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_pixel(input logic [15:0] dep, input logic [11:0] c, input logic [11:0] r);
        pending_pixels.push_back({dep, c, r});
    endtask

    // mostly pixels inside the radius with plausible depths, some full-range noise
    task automatic add_random(input int n);
        int k;
        logic [15:0] dep;
        int c, r, rad;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: dep = 16'd0;
                1, 2: dep = $urandom;
                default: dep = $urandom_range(4000, 300);
            endcase
            rad = radius_r;
            if ($urandom_range(3) == 0)
            begin
                c = $urandom_range(4095);
                r = $urandom_range(4095);
            end
            else
            begin
                c = int'(cx_r >> 4) + $urandom_range(2 * rad) - rad;
                r = int'(cy_r >> 4) + $urandom_range(2 * rad) - rad;
                c = c < 0 ? 0 : (c > 4095 ? 4095 : c);
                r = r < 0 ? 0 : (r > 4095 ? 4095 : r);
            end
            add_pixel(dep, c[11:0], r[11:0]);
        end
    endtask

    task automatic random_coeffs();
        write_reg(REG_GAIN, 32'd16777216 + $urandom_range(8388608) - 32'd4194304);
        write_reg(REG_OFFSET, $urandom_range(131072) - 32'd65536);
        write_reg(REG_HCURVE, $urandom);
        write_reg(REG_VCURVE, $urandom);
        write_reg(REG_RADIUS, $urandom_range(600, 20));
        write_reg(REG_CX, $urandom);
        write_reg(REG_CY, $urandom);
    endtask

    initial
    begin
        int ph;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, field extremes, masking and saturation cases
        add_pixel(16'd0, 12'd320, 12'd240);
        add_pixel(16'd1000, 12'd320, 12'd240);
        add_pixel(16'hFFFF, 12'd320, 12'd240);
        add_pixel(16'd1, 12'd320, 12'd240);
        add_pixel(16'd1000, 12'd0, 12'd0);
        add_pixel(16'd1000, 12'hFFF, 12'hFFF);
        add_pixel(16'd1000, 12'd470, 12'd240);
        add_pixel(16'd1000, 12'd469, 12'd240);
        add_pixel(16'd1000, 12'd320, 12'd90);
        drain();
        write_reg(REG_RADIUS, 32'h0000_0FFF);
        write_reg(REG_OFFSET, 32'h8000_0000);
        add_pixel(16'd500, 12'd320, 12'd240);
        add_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        drain();
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        add_pixel(16'd500, 12'd320, 12'd240);
        add_pixel(16'd1, 12'd0, 12'd0);
        drain();
        write_reg(REG_GAIN, 32'h8000_0000);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_HCURVE, 32'h7FFF_FFFF);
        write_reg(REG_VCURVE, 32'h8000_0000);
        write_reg(REG_CX, 32'h0000_FFFF);
        write_reg(REG_CY, 32'd0);
        write_reg(REG_NONE, 32'hDEAD_BEEF);
        add_pixel(16'd1, 12'd0, 12'd0);
        add_pixel(16'd800, 12'hFFF, 12'hFFF);
        add_pixel(16'd800, 12'd0, 12'hFFF);
        drain();
        write_reg(REG_RADIUS, 32'd0);
        add_pixel(16'd800, 12'd320, 12'd240);
        drain();
        write_reg(REG_GAIN, 32'd16777216);
        write_reg(REG_HCURVE, 32'd0);
        write_reg(REG_VCURVE, 32'd0);
        write_reg(REG_RADIUS, 32'd150);
        write_reg(REG_CX, 32'd5120);
        write_reg(REG_CY, 32'd3840);

        // random phases
        add_random(700);
        drain();
        for (ph = 0; ph < 5; ph++)
        begin
            random_coeffs();
            add_random(150);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d pixels, %0d results (%0d nonzero, %0d saturated)",
                 pixels_in, depths_out, nonzero_out, saturated_out);
        $display("coefficient sets included defaults, extremes and random values");
        if (mismatches == 0 && expected_depths.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/drf_pkg.sv
src/drf_if.sv
src/drf_cfg.sv
src/drf_recip.sv
src/drf_fit.sv
src/drf_quot.sv
src/depth_pixel_disparity_refit.sv
test/tb_depth_pixel_disparity_refit.sv
